// ===== src/assert_macros.svh =====
// Assertion macros shared by the pressure compensation RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define PSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define PSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/psc_pkg.sv =====
// Types, constants and the CRC-4 byte step for the pressure compensation block.
// No dependencies.
`default_nettype none

package psc_pkg;

	localparam int unsigned RawW     = 24;
	localparam int unsigned CoefW    = 16;
	localparam int unsigned InDataW  = 2 * RawW;
	localparam int unsigned ResW     = 32;
	localparam int unsigned OutDataW = 2 * ResW;
	localparam int unsigned CfgAddrW = 3;

	localparam int unsigned CrcBytes = 16;
	localparam int unsigned CrcCntW  = $clog2(CrcBytes + 1);

	localparam logic [CoefW-1:0]   CrcPoly     = 16'h3000;
	localparam logic [CoefW-1:0]   CrcDataMask = 16'h0FFF;
	localparam logic signed [31:0] TempBase    = 32'sd2000;
	localparam logic signed [17:0] QVeryLow    = -18'sd3500;
	localparam logic signed [18:0] VlOfs       = 19'sd3500;
	// ceil(2^31 / 10), exact quotient for dividends below 2^30
	localparam logic [27:0]        Recip10     = 28'hCCCCCCD;

	typedef enum logic [CfgAddrW-1:0] {
		REG_CRC = 3'd0,
		REG_C1  = 3'd1,
		REG_C2  = 3'd2,
		REG_C3  = 3'd3,
		REG_C4  = 3'd4,
		REG_C5  = 3'd5,
		REG_C6  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CoefW-1:0] c1;
		logic [CoefW-1:0] c2;
		logic [CoefW-1:0] c3;
		logic [CoefW-1:0] c4;
		logic [CoefW-1:0] c5;
		logic [CoefW-1:0] c6;
	} psc_coef_t;

	typedef struct packed {
		logic [RawW-1:0]    d1;
		logic signed [31:0] temp;
		logic signed [38:0] off2;
		logic signed [37:0] sens2;
	} psc_mid_t;

	typedef struct packed {
		logic busy;
		logic ok;
	} psc_crc_stat_t;

	function automatic logic [CoefW-1:0] crc_byte(input logic [CoefW-1:0] rem_in,
			input logic [7:0] data);
		logic [CoefW-1:0] r;
		r = rem_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/psc_crc.sv =====
// PROM CRC-4 checker: walks the eight PROM words one byte per cycle.
// Depends on psc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module psc_crc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic [psc_pkg::CoefW-1:0]  crc_word,
	input  psc_pkg::psc_coef_t         coef,
	output psc_pkg::psc_crc_stat_t     stat
);
	import psc_pkg::*;

	logic [CrcCntW-1:0] cnt_q;
	logic [CoefW-1:0]   rem_q;
	logic [CoefW-1:0]   words [8];
	logic [CoefW-1:0]   word_sel;
	logic [7:0]         byte_sel;
	logic               busy;

	always_comb begin
		words[0] = crc_word & CrcDataMask;
		words[1] = coef.c1;
		words[2] = coef.c2;
		words[3] = coef.c3;
		words[4] = coef.c4;
		words[5] = coef.c5;
		words[6] = coef.c6;
		words[7] = '0;
		word_sel = words[cnt_q[3:1]];
		byte_sel = cnt_q[0] ? word_sel[7:0] : word_sel[15:8];
		busy     = (cnt_q != CrcCntW'(CrcBytes));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
		end else if (restart) begin
			cnt_q <= '0;
			rem_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + 1'b1;
			rem_q <= crc_byte(rem_q, byte_sel);
		end
	end

	assign stat.busy = busy;
	assign stat.ok   = (rem_q[15:12] == crc_word[15:12]);

	`PSC_ASSERT(a_crc_done_after_last_byte, $fell(busy) |-> ($past(cnt_q) == CrcCntW'(CrcBytes - 1)), "CRC finished early")

endmodule

`default_nettype wire

// ===== src/psc_comp.sv =====
// First-order calibration and second-order band correction, seven stages.
// Produces TEMP2, OFF2 and SENS2 per sample. Depends on psc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module psc_comp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [psc_pkg::RawW-1:0]  raw_pressure,
	input  logic [psc_pkg::RawW-1:0]  raw_temperature,
	input  psc_pkg::psc_coef_t        coef,
	output logic                      out_valid,
	input  logic                      out_ready,
	output psc_pkg::psc_mid_t         mid
);
	import psc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	// s1: dT
	logic signed [24:0] dt_s1;
	logic [RawW-1:0]    d1_s1;
	// s2: products with dT
	logic signed [41:0] pt_s2, poff_s2, psens_s2;
	logic [47:0]        sq_s2;
	logic [RawW-1:0]    d1_s2;
	// s3: TEMP deviation, OFF, SENS, Ti candidates
	logic signed [17:0] q_s3;
	logic signed [35:0] off_s3, sens_s3;
	logic [16:0]        ti_lo_s3;
	logic [11:0]        ti_hi_s3;
	logic [RawW-1:0]    d1_s3;
	// s4: squares, band flags, final temperature
	logic [33:0]        dev2_s4, vl2_s4;
	logic               low_s4, vlow_s4;
	logic signed [31:0] temp_s4;
	logic signed [35:0] off_s4, sens_s4;
	logic [RawW-1:0]    d1_s4;
	// s5: constant multiples
	logic [35:0]        t3_s5;
	logic [36:0]        t5_s5, t7_s5;
	logic [33:0]        dev2_s5, vl2_s5;
	logic               low_s5, vlow_s5;
	logic signed [31:0] temp_s5;
	logic signed [35:0] off_s5, sens_s5;
	logic [RawW-1:0]    d1_s5;
	// s6: OFFi, SENSi
	logic [37:0]        offi_s6;
	logic [36:0]        sensi_s6;
	logic               low_s6;
	logic signed [31:0] temp_s6;
	logic signed [35:0] off_s6, sens_s6;
	logic [RawW-1:0]    d1_s6;
	// s7: OFF2, SENS2
	logic signed [38:0] off2_s7;
	logic signed [37:0] sens2_s7;
	logic signed [31:0] temp_s7;
	logic [RawW-1:0]    d1_s7;

	logic signed [24:0] dt_in;
	logic [23:0]        adt;
	logic signed [16:0] c3s, c4s, c6s;
	logic signed [18:0] q_fl, q_rnd;
	logic [49:0]        sq3;
	logic signed [35:0] off_nx, sens_nx;
	logic [16:0]        aq, avl;
	logic signed [18:0] vl;
	logic [16:0]        ti_sel;
	logic signed [31:0] q32, temp_nx;
	logic [37:0]        offi_nx;
	logic [36:0]        sensi_nx;

	assign ld7       = !v_s7 || out_ready;
	assign ld6       = !v_s6 || ld7;
	assign ld5       = !v_s5 || ld6;
	assign ld4       = !v_s4 || ld5;
	assign ld3       = !v_s3 || ld4;
	assign ld2       = !v_s2 || ld3;
	assign ld1       = !v_s1 || ld2;
	assign in_ready  = ld1;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
			if (ld7) v_s7 <= v_s6;
		end
	end

	always_comb begin
		dt_in   = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'h00});
		adt     = dt_s1[24] ? 24'(-dt_s1) : dt_s1[23:0];
		c3s     = $signed({1'b0, coef.c3});
		c4s     = $signed({1'b0, coef.c4});
		c6s     = $signed({1'b0, coef.c6});

		// divide by 2^23 toward zero
		q_fl    = $signed(pt_s2[41:23]);
		q_rnd   = q_fl + ((pt_s2[41] && (|pt_s2[22:0])) ? 19'sd1 : 19'sd0);
		sq3     = {2'b00, sq_s2} + {1'b0, sq_s2, 1'b0};
		off_nx  = $signed({4'h0, coef.c2, 16'h0000}) + $signed(poff_s2[41:7]);
		sens_nx = $signed({5'h00, coef.c1, 15'h0000}) + $signed(psens_s2[41:8]);

		aq      = q_s3[17] ? 17'(-q_s3) : q_s3[16:0];
		vl      = $signed({q_s3[17], q_s3}) + VlOfs;
		avl     = 17'(-vl);
		ti_sel  = q_s3[17] ? ti_lo_s3 : {5'b00000, ti_hi_s3};
		q32     = {{14{q_s3[17]}}, q_s3};
		temp_nx = q32 + TempBase - $signed({15'h0000, ti_sel});

		if (low_s5) begin
			offi_nx  = {3'b000, t3_s5[35:1]} + (vlow_s5 ? {1'b0, t7_s5} : 38'd0);
			sensi_nx = {3'b000, t5_s5[36:3]} + (vlow_s5 ? {1'b0, vl2_s5, 2'b00} : 37'd0);
		end else begin
			offi_nx  = {8'h00, dev2_s5[33:4]};
			sensi_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			dt_s1 <= dt_in;
			d1_s1 <= raw_pressure;
		end
		if (ld2) begin
			pt_s2    <= dt_s1 * c6s;
			poff_s2  <= dt_s1 * c4s;
			psens_s2 <= dt_s1 * c3s;
			sq_s2    <= adt * adt;
			d1_s2    <= d1_s1;
		end
		if (ld3) begin
			q_s3     <= q_rnd[17:0];
			off_s3   <= off_nx;
			sens_s3  <= sens_nx;
			ti_lo_s3 <= sq3[49:33];
			ti_hi_s3 <= sq_s2[47:36];
			d1_s3    <= d1_s2;
		end
		if (ld4) begin
			dev2_s4 <= aq * aq;
			vl2_s4  <= avl * avl;
			low_s4  <= q_s3[17];
			vlow_s4 <= (q_s3 < QVeryLow);
			temp_s4 <= temp_nx;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			d1_s4   <= d1_s3;
		end
		if (ld5) begin
			t3_s5   <= {2'b00, dev2_s4} + {1'b0, dev2_s4, 1'b0};
			t5_s5   <= {3'b000, dev2_s4} + {1'b0, dev2_s4, 2'b00};
			t7_s5   <= {vl2_s4, 3'b000} - {3'b000, vl2_s4};
			dev2_s5 <= dev2_s4;
			vl2_s5  <= vl2_s4;
			low_s5  <= low_s4;
			vlow_s5 <= vlow_s4;
			temp_s5 <= temp_s4;
			off_s5  <= off_s4;
			sens_s5 <= sens_s4;
			d1_s5   <= d1_s4;
		end
		if (ld6) begin
			offi_s6  <= offi_nx;
			sensi_s6 <= sensi_nx;
			low_s6   <= low_s5;
			temp_s6  <= temp_s5;
			off_s6   <= off_s5;
			sens_s6  <= sens_s5;
			d1_s6    <= d1_s5;
		end
		if (ld7) begin
			off2_s7  <= off_s6 - $signed({1'b0, offi_s6});
			sens2_s7 <= sens_s6 - $signed({1'b0, sensi_s6});
			temp_s7  <= temp_s6;
			d1_s7    <= d1_s6;
		end
	end

	assign mid.d1    = d1_s7;
	assign mid.temp  = temp_s7;
	assign mid.off2  = off2_s7;
	assign mid.sens2 = sens2_s7;

	`PSC_NEVER(a_high_band_no_sensi, v_s6 && !low_s6 && (sensi_s6 != '0), "SENSi set in high band")
	`PSC_ASSERT(a_vlow_implies_low, v_s4 && vlow_s4 |-> low_s4, "very-low band outside low band")

endmodule

`default_nettype wire

// ===== src/psc_press.sv =====
// Pressure stage: D1*SENS2 in two partial products, offset removal, scaling
// and truncating divide by ten, six stages. Depends on psc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module psc_press (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  psc_pkg::psc_mid_t                mid,
	input  logic                             crc_ok,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [psc_pkg::ResW-1:0]  temperature_centi,
	output logic signed [psc_pkg::ResW-1:0]  pressure_millibar,
	output logic                             prom_ok
);
	import psc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld1, ld2, ld3, ld4, ld5, ld6;

	logic [43:0]        lo_s1;
	logic signed [42:0] hi_s1;
	logic signed [38:0] off2_s1, off2_s2;
	logic signed [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6;
	logic [62:0]        prod_s2;
	logic signed [27:0] pc_s3;
	logic [27:0]        u_s4;
	logic               neg_s4, neg_s5;
	logic [24:0]        quot_s5;
	logic signed [31:0] pm_s6;
	logic               ok_s6;

	logic signed [42:0] diff;
	logic [55:0]        mq;

	assign ld6       = !v_s6 || out_ready;
	assign ld5       = !v_s5 || ld6;
	assign ld4       = !v_s4 || ld5;
	assign ld3       = !v_s3 || ld4;
	assign ld2       = !v_s2 || ld3;
	assign ld1       = !v_s1 || ld2;
	assign in_ready  = ld1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		diff = $signed(prod_s2[62:21]) - off2_s2;
		mq   = u_s4 * Recip10;
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			lo_s1   <= mid.d1 * mid.sens2[19:0];
			hi_s1   <= $signed({1'b0, mid.d1}) * $signed(mid.sens2[37:20]);
			off2_s1 <= mid.off2;
			temp_s1 <= mid.temp;
		end
		if (ld2) begin
			prod_s2 <= {hi_s1, 20'h00000} + {19'h00000, lo_s1};
			off2_s2 <= off2_s1;
			temp_s2 <= temp_s1;
		end
		if (ld3) begin
			pc_s3   <= diff[40:13];
			temp_s3 <= temp_s2;
		end
		if (ld4) begin
			neg_s4  <= pc_s3[27];
			u_s4    <= pc_s3[27] ? 28'(-pc_s3) : pc_s3;
			temp_s4 <= temp_s3;
		end
		if (ld5) begin
			quot_s5 <= mq[55:31];
			neg_s5  <= neg_s4;
			temp_s5 <= temp_s4;
		end
		if (ld6) begin
			pm_s6   <= neg_s5 ? -$signed({7'h00, quot_s5}) : $signed({7'h00, quot_s5});
			temp_s6 <= temp_s5;
			ok_s6   <= crc_ok;
		end
	end

	assign temperature_centi = temp_s6;
	assign pressure_millibar = pm_s6;
	assign prom_ok           = ok_s6;

	`PSC_ASSERT(a_stall_holds_quot, v_s5 && !ld6 |=> v_s5 && $stable(quot_s5), "stalled stage changed")

endmodule

`default_nettype wire

// ===== src/pressure_sensor_compensation.sv =====
// Pressure/temperature compensation top: config registers, CRC checker, pipeline.
// Depends on psc_pkg, psc_crc, psc_comp, psc_press and assert_macros.svh.
//
// One (D1, D2) sample pair per s_axis transfer, one result per m_axis transfer.
// Thirteen register stages; the pipeline takes a new sample every cycle while
// s_axis_tready is high; stages hold their data under m_axis_tready backpressure
// and empty stages keep accepting. After reset and after every configuration
// write the PROM CRC-4 is recomputed one byte a cycle, and s_axis_tready stays
// low until all 16 bytes are done.
`default_nettype none
`include "assert_macros.svh"

module pressure_sensor_compensation (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// raw_pressure [23:0], raw_temperature [47:24]
	input  logic [psc_pkg::InDataW-1:0]        s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// temperature_centi [31:0], pressure_millibar [63:32]
	output logic [psc_pkg::OutDataW-1:0]       m_axis_tdata,
	// prom_ok [0]
	output logic                               m_axis_tuser,
	input  logic                               cfg_we,
	input  logic [psc_pkg::CfgAddrW-1:0]       cfg_addr,
	input  logic [psc_pkg::CoefW-1:0]          cfg_wdata
);
	import psc_pkg::*;

	logic [CoefW-1:0]   crc_word_q;
	psc_coef_t          coef_q;
	psc_crc_stat_t      crc_stat;
	psc_mid_t           mid;
	logic               comp_in_ready;
	logic               mid_valid, mid_ready;
	logic signed [31:0] temperature_centi, pressure_millibar;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_word_q <= '0;
			coef_q     <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_CRC: crc_word_q <= cfg_wdata;
				REG_C1:  coef_q.c1  <= cfg_wdata;
				REG_C2:  coef_q.c2  <= cfg_wdata;
				REG_C3:  coef_q.c3  <= cfg_wdata;
				REG_C4:  coef_q.c4  <= cfg_wdata;
				REG_C5:  coef_q.c5  <= cfg_wdata;
				REG_C6:  coef_q.c6  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	psc_crc u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.crc_word (crc_word_q),
		.coef     (coef_q),
		.stat     (crc_stat)
	);

	assign s_axis_tready = comp_in_ready && !crc_stat.busy;

	psc_comp u_comp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid && !crc_stat.busy),
		.in_ready        (comp_in_ready),
		.raw_pressure    (s_axis_tdata[RawW-1:0]),
		.raw_temperature (s_axis_tdata[2*RawW-1:RawW]),
		.coef            (coef_q),
		.out_valid       (mid_valid),
		.out_ready       (mid_ready),
		.mid             (mid)
	);

	psc_press u_press (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (mid_valid),
		.in_ready          (mid_ready),
		.mid               (mid),
		.crc_ok            (crc_stat.ok),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.temperature_centi (temperature_centi),
		.pressure_millibar (pressure_millibar),
		.prom_ok           (m_axis_tuser)
	);

	assign m_axis_tdata = {pressure_millibar, temperature_centi};

	`PSC_ASSERT(a_cfg_write_holds_input, cfg_we |=> !(s_axis_tvalid && s_axis_tready), "input taken during CRC update")

endmodule

`default_nettype wire
